@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the disk pair collision core.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define DPEC_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("disk pair collision check failed");

// Checks that a consequent holds whenever its antecedent holds.
`define DPEC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("disk pair collision check failed");

`endif

@@ rtl/dpec_pkg.sv @@
// Types and constants of the disk pair elastic collision core.
// Depends on nothing; used by the core and its checker.
package dpec_pkg;

   localparam int VW   = 24;          // velocity and position width
   localparam int RW   = 23;          // radius width
   localparam int DW   = VW + 1;      // center difference width
   localparam int D2W  = 2 * DW;      // squared distance width
   localparam int LW   = 2 * VW;      // squared diameter width
   localparam int PXW  = VW + DW;     // one velocity times one difference
   localparam int PSW  = PXW + 1;     // projection width
   localparam int QSW  = PSW + 1;     // projection difference width
   localparam int QLW  = 26;          // low slice of the projection difference
   localparam int QHW  = QSW - QLW;   // high slice of the projection difference
   localparam int PW   = DW + QSW;    // full numerator width
   localparam int QW   = 26;          // quotient bits, one per divider stage
   localparam int REMW = PW - QW;     // partial remainder width
   localparam int FRAC_BITS = 12;     // fraction bits of the number format
   localparam int LATENCY = 6 + QW + 2;

   typedef struct packed {
      logic signed [VW-1:0] pos_x_a;
      logic signed [VW-1:0] pos_y_a;
      logic signed [VW-1:0] vel_x_a;
      logic signed [VW-1:0] vel_y_a;
      logic signed [VW-1:0] pos_x_b;
      logic signed [VW-1:0] pos_y_b;
      logic signed [VW-1:0] vel_x_b;
      logic signed [VW-1:0] vel_y_b;
   } req_type;

   typedef struct packed {
      logic signed [VW-1:0] new_vel_x_a;
      logic signed [VW-1:0] new_vel_y_a;
      logic signed [VW-1:0] new_vel_x_b;
      logic signed [VW-1:0] new_vel_y_b;
      logic                 exchanged;
   } rsp_type;

   typedef struct packed {
      logic                 swap;
      logic                 neg_x;
      logic                 neg_y;
      logic signed [VW-1:0] vel_x_a;
      logic signed [VW-1:0] vel_y_a;
      logic signed [VW-1:0] vel_x_b;
      logic signed [VW-1:0] vel_y_b;
   } side_type;

   typedef struct packed {
      logic [REMW-1:0] rem;
      logic [QW-1:0]   low;
      logic [QW-1:0]   quot;
   } div_type;

endpackage

@@ rtl/disk_pair_elastic_collision_core.sv @@
// Disk pair elastic collision core: top level and only datapath module.
// Depends on dpec_pkg for payload types and widths.
//
// One disk pair is taken in every clock cycle and its result appears on rsp_payload with
// rsp_valid once it has passed every pipeline stage; the receiver cannot stall, so
// busy is high only during reset. The pipeline has six setup stages (differences,
// products, sums, tests, split products, full numerator), one divider stage for each of
// the 26 quotient bits, and two stages for rounding and saturation. The user must write
// the radius register only while no transaction is in flight; the core does not enforce it.
module disk_pair_elastic_collision_core
   import dpec_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_payload,
   output logic          rsp_valid,
   output rsp_type       rsp_payload,
   input  logic          csr_we,
   input  logic [RW-1:0] csr_wdata
);

   localparam logic signed [QW+2:0] VMAX = (QW+3)'(2 ** (VW - 1) - 1);
   localparam logic signed [QW+2:0] VMIN = -(QW+3)'(2 ** (VW - 1));

   function automatic logic signed [VW-1:0] sat(input logic signed [QW+2:0] v);
      logic signed [VW-1:0] r;
      if (v > VMAX) begin
         r = VMAX[VW-1:0];
      end else if (v < VMIN) begin
         r = VMIN[VW-1:0];
      end else begin
         r = v[VW-1:0];
      end
      return r;
   endfunction

   function automatic div_type div_step(input div_type cur, input logic [REMW-1:0] den);
      logic [REMW:0] t;
      div_type       nxt;
      t = {cur.rem, cur.low[QW-1]};
      nxt.low = {cur.low[QW-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
         nxt.rem  = REMW'(t - {1'b0, den});
         nxt.quot = {cur.quot[QW-2:0], 1'b1};
      end else begin
         nxt.rem  = t[REMW-1:0];
         nxt.quot = {cur.quot[QW-2:0], 1'b0};
      end
      return nxt;
   endfunction

   logic [RW-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RW'(4096);
      end else if (csr_we) begin
         radius_ff <= csr_wdata;
      end
   end

   assign busy = reset;

   // Stage A: center differences.
   logic                 a_vld_ff;
   side_type             a_side_ff, a_side_in;
   logic signed [DW-1:0] a_dx_ff, a_dx_in, a_dy_ff, a_dy_in;

   always_comb begin
      a_side_in.swap    = 1'b0;
      a_side_in.neg_x   = 1'b0;
      a_side_in.neg_y   = 1'b0;
      a_side_in.vel_x_a = req_payload.vel_x_a;
      a_side_in.vel_y_a = req_payload.vel_y_a;
      a_side_in.vel_x_b = req_payload.vel_x_b;
      a_side_in.vel_y_b = req_payload.vel_y_b;
      a_dx_in = $signed({req_payload.pos_x_b[VW-1], req_payload.pos_x_b})
              - $signed({req_payload.pos_x_a[VW-1], req_payload.pos_x_a});
      a_dy_in = $signed({req_payload.pos_y_b[VW-1], req_payload.pos_y_b})
              - $signed({req_payload.pos_y_a[VW-1], req_payload.pos_y_a});
   end

   // Stage B: products.
   logic                  b_vld_ff;
   side_type              b_side_ff;
   logic signed [DW-1:0]  b_dx_ff, b_dy_ff;
   logic signed [D2W-1:0] b_dxx_ff, b_dxx_in, b_dyy_ff, b_dyy_in;
   logic signed [PXW-1:0] b_pxa_ff, b_pxa_in, b_pya_ff, b_pya_in;
   logic signed [PXW-1:0] b_pxb_ff, b_pxb_in, b_pyb_ff, b_pyb_in;
   logic [LW-1:0]         b_lim_ff, b_lim_in;
   logic [VW-1:0]         b_diam;

   always_comb begin
      b_dxx_in = a_dx_ff * a_dx_ff;
      b_dyy_in = a_dy_ff * a_dy_ff;
      b_pxa_in = a_side_ff.vel_x_a * a_dx_ff;
      b_pya_in = a_side_ff.vel_y_a * a_dy_ff;
      b_pxb_in = a_side_ff.vel_x_b * a_dx_ff;
      b_pyb_in = a_side_ff.vel_y_b * a_dy_ff;
      b_diam   = {radius_ff, 1'b0};
      b_lim_in = b_diam * b_diam;
   end

   // Stage C: squared distance and projections.
   logic                  c_vld_ff;
   side_type              c_side_ff;
   logic signed [DW-1:0]  c_dx_ff, c_dy_ff;
   logic [D2W-1:0]        c_dist2_ff, c_dist2_in;
   logic signed [PSW-1:0] c_pa_ff, c_pa_in, c_pb_ff, c_pb_in;
   logic [LW-1:0]         c_lim_ff;

   always_comb begin
      c_dist2_in = $unsigned(b_dxx_ff) + $unsigned(b_dyy_ff);
      c_pa_in    = b_pxa_ff + b_pya_ff;
      c_pb_in    = b_pxb_ff + b_pyb_ff;
   end

   // Stage D: contact and closing tests, magnitudes and signs.
   logic                  d_vld_ff;
   side_type              d_side_ff, d_side_in;
   logic [D2W-1:0]        d_den_ff;
   logic [QSW-1:0]        d_qmag_ff, d_qmag_in;
   logic [DW-1:0]         d_dxmag_ff, d_dxmag_in, d_dymag_ff, d_dymag_in;
   logic signed [QSW-1:0] d_q;
   logic                  d_hit, d_close;

   always_comb begin
      d_q     = c_pb_ff - c_pa_ff;
      d_hit   = (c_dist2_ff < {2'b00, c_lim_ff}) && (c_dist2_ff != '0);
      d_close = (c_pb_ff > 0 && c_pb_ff < c_pa_ff) || (c_pa_ff < 0 && c_pb_ff < c_pa_ff)
             || (c_pa_ff > 0 && c_pb_ff < 0);
      d_qmag_in  = d_q[QSW-1] ? $unsigned(-d_q) : $unsigned(d_q);
      d_dxmag_in = c_dx_ff[DW-1] ? $unsigned(-c_dx_ff) : $unsigned(c_dx_ff);
      d_dymag_in = c_dy_ff[DW-1] ? $unsigned(-c_dy_ff) : $unsigned(c_dy_ff);
      d_side_in       = c_side_ff;
      d_side_in.swap  = d_hit && d_close;
      d_side_in.neg_x = c_dx_ff[DW-1] ^ d_q[QSW-1];
      d_side_in.neg_y = c_dy_ff[DW-1] ^ d_q[QSW-1];
   end

   // Stage E: split products of the numerators.
   logic                  e_vld_ff;
   side_type              e_side_ff;
   logic [D2W-1:0]        e_den_ff;
   logic [DW+QLW-1:0]     e_xlo_ff, e_xlo_in, e_ylo_ff, e_ylo_in;
   logic [DW+QHW-1:0]     e_xhi_ff, e_xhi_in, e_yhi_ff, e_yhi_in;

   always_comb begin
      e_xlo_in = d_dxmag_ff * d_qmag_ff[QLW-1:0];
      e_ylo_in = d_dymag_ff * d_qmag_ff[QLW-1:0];
      e_xhi_in = d_dxmag_ff * d_qmag_ff[QSW-1:QLW];
      e_yhi_in = d_dymag_ff * d_qmag_ff[QSW-1:QLW];
   end

   // Stage F: full numerators.
   logic           f_vld_ff;
   side_type       f_side_ff;
   logic [D2W-1:0] f_den_ff;
   logic [PW-1:0]  f_px_ff, f_px_in, f_py_ff, f_py_in;

   always_comb begin
      f_px_in = {e_xhi_ff, QLW'(0)} + PW'(e_xlo_ff);
      f_py_in = {e_yhi_ff, QLW'(0)} + PW'(e_ylo_ff);
   end

   // Divider stages, one quotient bit each.
   logic           dv_vld_ff  [QW];
   side_type       dv_side_ff [QW];
   logic [D2W-1:0] dv_den_ff  [QW];
   div_type        dv_x_ff [QW], dv_x_in [QW], dv_y_ff [QW], dv_y_in [QW];
   div_type        dv_x_seed, dv_y_seed;

   always_comb begin
      dv_x_seed.rem  = f_px_ff[PW-1:QW];
      dv_x_seed.low  = f_px_ff[QW-1:0];
      dv_x_seed.quot = '0;
      dv_y_seed.rem  = f_py_ff[PW-1:QW];
      dv_y_seed.low  = f_py_ff[QW-1:0];
      dv_y_seed.quot = '0;
      dv_x_in[0] = div_step(dv_x_seed, f_den_ff);
      dv_y_in[0] = div_step(dv_y_seed, f_den_ff);
      for (int k = 1; k < QW; k++) begin
         dv_x_in[k] = div_step(dv_x_ff[k-1], dv_den_ff[k-1]);
         dv_y_in[k] = div_step(dv_y_ff[k-1], dv_den_ff[k-1]);
      end
   end

   // Stage R1: rounding to nearest, ties away from zero, and sign.
   logic                  r1_vld_ff;
   side_type              r1_side_ff;
   logic signed [QW+1:0]  r1_dx_ff, r1_dx_in, r1_dy_ff, r1_dy_in;
   logic [QW:0]           r1_mx, r1_my;
   logic                  r1_rx, r1_ry;

   always_comb begin
      r1_rx = {dv_x_ff[QW-1].rem, 1'b0} >= {1'b0, dv_den_ff[QW-1]};
      r1_ry = {dv_y_ff[QW-1].rem, 1'b0} >= {1'b0, dv_den_ff[QW-1]};
      r1_mx = {1'b0, dv_x_ff[QW-1].quot} + (QW+1)'(r1_rx);
      r1_my = {1'b0, dv_y_ff[QW-1].quot} + (QW+1)'(r1_ry);
      r1_dx_in = dv_side_ff[QW-1].neg_x ? -$signed({1'b0, r1_mx}) : $signed({1'b0, r1_mx});
      r1_dy_in = dv_side_ff[QW-1].neg_y ? -$signed({1'b0, r1_my}) : $signed({1'b0, r1_my});
   end

   // Stage R2: velocity update and saturation into the output register.
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;
   logic signed [QW+2:0] s_xa, s_ya, s_xb, s_yb;

   always_comb begin
      s_xa = r1_side_ff.vel_x_a + r1_dx_ff;
      s_ya = r1_side_ff.vel_y_a + r1_dy_ff;
      s_xb = r1_side_ff.vel_x_b - r1_dx_ff;
      s_yb = r1_side_ff.vel_y_b - r1_dy_ff;
      if (r1_side_ff.swap) begin
         rsp_in.new_vel_x_a = sat(s_xa);
         rsp_in.new_vel_y_a = sat(s_ya);
         rsp_in.new_vel_x_b = sat(s_xb);
         rsp_in.new_vel_y_b = sat(s_yb);
      end else begin
         rsp_in.new_vel_x_a = r1_side_ff.vel_x_a;
         rsp_in.new_vel_y_a = r1_side_ff.vel_y_a;
         rsp_in.new_vel_x_b = r1_side_ff.vel_x_b;
         rsp_in.new_vel_y_b = r1_side_ff.vel_y_b;
      end
      rsp_in.exchanged = r1_side_ff.swap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         f_vld_ff     <= 1'b0;
         r1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < QW; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
      end else begin
         a_vld_ff     <= start && !busy;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= b_vld_ff;
         d_vld_ff     <= c_vld_ff;
         e_vld_ff     <= d_vld_ff;
         f_vld_ff     <= e_vld_ff;
         dv_vld_ff[0] <= f_vld_ff;
         for (int k = 1; k < QW; k++) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
         r1_vld_ff    <= dv_vld_ff[QW-1];
         rsp_valid_ff <= r1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_side_ff  <= a_side_in;
      a_dx_ff    <= a_dx_in;
      a_dy_ff    <= a_dy_in;
      b_side_ff  <= a_side_ff;
      b_dx_ff    <= a_dx_ff;
      b_dy_ff    <= a_dy_ff;
      b_dxx_ff   <= b_dxx_in;
      b_dyy_ff   <= b_dyy_in;
      b_pxa_ff   <= b_pxa_in;
      b_pya_ff   <= b_pya_in;
      b_pxb_ff   <= b_pxb_in;
      b_pyb_ff   <= b_pyb_in;
      b_lim_ff   <= b_lim_in;
      c_side_ff  <= b_side_ff;
      c_dx_ff    <= b_dx_ff;
      c_dy_ff    <= b_dy_ff;
      c_dist2_ff <= c_dist2_in;
      c_pa_ff    <= c_pa_in;
      c_pb_ff    <= c_pb_in;
      c_lim_ff   <= b_lim_ff;
      d_side_ff  <= d_side_in;
      d_den_ff   <= c_dist2_ff;
      d_qmag_ff  <= d_qmag_in;
      d_dxmag_ff <= d_dxmag_in;
      d_dymag_ff <= d_dymag_in;
      e_side_ff  <= d_side_ff;
      e_den_ff   <= d_den_ff;
      e_xlo_ff   <= e_xlo_in;
      e_ylo_ff   <= e_ylo_in;
      e_xhi_ff   <= e_xhi_in;
      e_yhi_ff   <= e_yhi_in;
      f_side_ff  <= e_side_ff;
      f_den_ff   <= e_den_ff;
      f_px_ff    <= f_px_in;
      f_py_ff    <= f_py_in;
      dv_side_ff[0] <= f_side_ff;
      dv_den_ff[0]  <= f_den_ff;
      for (int k = 1; k < QW; k++) begin
         dv_side_ff[k] <= dv_side_ff[k-1];
         dv_den_ff[k]  <= dv_den_ff[k-1];
      end
      for (int k = 0; k < QW; k++) begin
         dv_x_ff[k] <= dv_x_in[k];
         dv_y_ff[k] <= dv_y_in[k];
      end
      r1_side_ff <= dv_side_ff[QW-1];
      r1_dx_ff   <= r1_dx_in;
      r1_dy_ff   <= r1_dy_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ rtl/dpec_checker.sv @@
// Port checker of the disk pair elastic collision core, bound to its top level.
// Depends on dpec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dpec_checker
   import dpec_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_valid,
   input rsp_type rsp_payload
);

   localparam int CW = $clog2(LATENCY + 1);

   logic [CW-1:0] warm_ff;
   logic          warm;

   always_ff @(posedge clock) begin
      if (reset) begin
         warm_ff <= '0;
      end else if (warm_ff != CW'(LATENCY)) begin
         warm_ff <= warm_ff + 1'b1;
      end
   end

   assign warm = (warm_ff == CW'(LATENCY));

   `DPEC_ASSERT_ALWAYS(a_no_early_rsp, clock, reset, warm || !rsp_valid)

   `DPEC_ASSERT_IMPLY(a_rsp_timing, clock, reset, warm, rsp_valid == $past(start && !busy, LATENCY))

   `DPEC_ASSERT_IMPLY(a_pass_through, clock, reset, warm && rsp_valid && !rsp_payload.exchanged, rsp_payload.new_vel_x_a == $past(req_payload.vel_x_a, LATENCY) && rsp_payload.new_vel_y_b == $past(req_payload.vel_y_b, LATENCY))

   `DPEC_ASSERT_IMPLY(a_exchange_apart, clock, reset, warm && rsp_valid && rsp_payload.exchanged, $past(req_payload.pos_x_a != req_payload.pos_x_b || req_payload.pos_y_a != req_payload.pos_y_b, LATENCY))

endmodule

bind disk_pair_elastic_collision_core dpec_checker u_dpec_checker (.*);

@@ tb/sv/disk_pair_elastic_collision_core_tb.sv @@
// Self-checking testbench for disk_pair_elastic_collision_core: directed and random disk pairs
// across several radius settings, each result checked against an in-bench collision predictor.
// Depends on dpec_pkg and the core RTL.
module disk_pair_elastic_collision_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dpec_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          start = 1'b0;
   logic          busy;
   req_type       req_payload = '0;
   logic          rsp_valid;
   rsp_type       rsp_payload;
   logic          csr_we = 1'b0;
   logic [RW-1:0] csr_wdata = '0;

   req_type       pairs_to_send[$];
   rsp_type       velocities_due[$];
   logic [RW-1:0] radius_now = 23'd4096;
   int            sender_idle_pct = 0;
   int            errors = 0;

   disk_pair_elastic_collision_core DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint rounded_delta(longint dc, longint q, longint den);
      logic [127:0] num, quo, rem, d128;
      longint       ma, mq, m;
      ma = (dc < 0) ? -dc : dc;
      mq = (q < 0) ? -q : q;
      d128 = 128'(den);
      num = 128'(ma) * 128'(mq);
      quo = num / d128;
      rem = num % d128;
      if (rem >= d128 - rem) quo = quo + 1;
      m = longint'(quo[62:0]);
      return ((dc < 0) != (q < 0)) ? -m : m;
   endfunction

   function automatic logic [VW-1:0] clamp_vel(longint v);
      if (v > 8388607) return 24'sd8388607;
      if (v < -8388608) return 24'h800000;
      return v[VW-1:0];
   endfunction

   function automatic rsp_type collide(req_type r, logic [RW-1:0] rad);
      longint  xa, ya, vxa, vya, xb, yb, vxb, vyb, dx, dy, dist2, diam, lim;
      longint  pa, pb, ddx, ddy;
      rsp_type o;
      xa = r.pos_x_a;  ya = r.pos_y_a;  vxa = r.vel_x_a;  vya = r.vel_y_a;
      xb = r.pos_x_b;  yb = r.pos_y_b;  vxb = r.vel_x_b;  vyb = r.vel_y_b;
      dx = xb - xa;
      dy = yb - ya;
      dist2 = dx * dx + dy * dy;
      diam = 2 * longint'(rad);
      lim = diam * diam;
      o.exchanged = 1'b0;
      if (dist2 < lim && dist2 != 0) begin
         pa = vxa * dx + vya * dy;
         pb = vxb * dx + vyb * dy;
         if ((pb > 0 && pb < pa) || (pa < 0 && pb < pa) || (pa > 0 && pb < 0)) begin
            ddx = rounded_delta(dx, pb - pa, dist2);
            ddy = rounded_delta(dy, pb - pa, dist2);
            vxa = vxa + ddx;
            vya = vya + ddy;
            vxb = vxb - ddx;
            vyb = vyb - ddy;
            o.exchanged = 1'b1;
         end
      end
      o.new_vel_x_a = clamp_vel(vxa);
      o.new_vel_y_a = clamp_vel(vya);
      o.new_vel_x_b = clamp_vel(vxb);
      o.new_vel_y_b = clamp_vel(vyb);
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pairs_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            start <= 1'b1;
            req_payload <= pairs_to_send.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) velocities_due.push_back(collide(req_payload, radius_now));
         if (rsp_valid) begin
            if (velocities_due.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_payload);
               errors++;
            end else begin
               want = velocities_due.pop_front();
               if (want.new_vel_x_a !== rsp_payload.new_vel_x_a)
                  $display("%0t: new_vel_x_a expected %0d actual %0d", $time,
                           want.new_vel_x_a, rsp_payload.new_vel_x_a);
               if (want.new_vel_y_a !== rsp_payload.new_vel_y_a)
                  $display("%0t: new_vel_y_a expected %0d actual %0d", $time,
                           want.new_vel_y_a, rsp_payload.new_vel_y_a);
               if (want.new_vel_x_b !== rsp_payload.new_vel_x_b)
                  $display("%0t: new_vel_x_b expected %0d actual %0d", $time,
                           want.new_vel_x_b, rsp_payload.new_vel_x_b);
               if (want.new_vel_y_b !== rsp_payload.new_vel_y_b)
                  $display("%0t: new_vel_y_b expected %0d actual %0d", $time,
                           want.new_vel_y_b, rsp_payload.new_vel_y_b);
               if (want.exchanged !== rsp_payload.exchanged)
                  $display("%0t: exchanged expected %0b actual %0b", $time,
                           want.exchanged, rsp_payload.exchanged);
               if (want !== rsp_payload) errors++;
            end
         end
      end
   end

   function automatic logic [VW-1:0] rand_vel();
      case ($urandom_range(5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($signed($urandom_range(0, 16384)) - 8192);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic req_type random_pair(logic [RW-1:0] rad);
      req_type r;
      longint  m, ox, oy, bx, by;
      r.pos_x_a = 24'($urandom);
      r.pos_y_a = 24'($urandom);
      r.vel_x_a = rand_vel();
      r.vel_y_a = rand_vel();
      r.vel_x_b = rand_vel();
      r.vel_y_b = rand_vel();
      case ($urandom_range(7))
         0: begin
            r.pos_x_b = 24'($urandom);
            r.pos_y_b = 24'($urandom);
         end
         1: begin
            r.pos_x_b = r.pos_x_a;
            r.pos_y_b = r.pos_y_a;
         end
         default: begin
            m = 2 * longint'(rad) + 2;
            if (m > 8388607) m = 8388607;
            ox = longint'($urandom_range(0, 32'(2 * m))) - m;
            oy = longint'($urandom_range(0, 32'(2 * m))) - m;
            bx = longint'(r.pos_x_a) + ox;
            by = longint'(r.pos_y_a) + oy;
            if (bx > 8388607 || bx < -8388608) bx = longint'(r.pos_x_a) - ox;
            if (by > 8388607 || by < -8388608) by = longint'(r.pos_y_a) - oy;
            r.pos_x_b = bx[VW-1:0];
            r.pos_y_b = by[VW-1:0];
         end
      endcase
      return r;
   endfunction

   task automatic settle();
      while (pairs_to_send.size() > 0 || start || velocities_due.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_radius(logic [RW-1:0] value);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      radius_now <= value;
      @(posedge clock);
   endtask

   task automatic random_phase(logic [RW-1:0] value, int idle, int count);
      set_radius(value);
      sender_idle_pct = idle;
      repeat (count) pairs_to_send.push_back(random_pair(value));
   endtask

   function automatic req_type pair_of(int xa, int ya, int vxa, int vya,
                                       int xb, int yb, int vxb, int vyb);
      req_type r;
      r.pos_x_a = 24'(xa); r.pos_y_a = 24'(ya); r.vel_x_a = 24'(vxa); r.vel_y_a = 24'(vya);
      r.pos_x_b = 24'(xb); r.pos_y_b = 24'(yb); r.vel_x_b = 24'(vxb); r.vel_y_b = 24'(vyb);
      return r;
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed pairs at the reset radius of one unit.
      pairs_to_send.push_back(pair_of(100, 100, 4096, 0, 100, 100, -4096, 0));
      pairs_to_send.push_back(pair_of(0, 0, 4096, 0, 100000, 0, -4096, 0));
      pairs_to_send.push_back(pair_of(0, 0, 4096, 0, 8192, 0, -4096, 0));
      pairs_to_send.push_back(pair_of(0, 0, 4096, 0, 8191, 0, -4096, 0));
      pairs_to_send.push_back(pair_of(0, 0, -4096, 0, 4000, 0, 4096, 0));
      pairs_to_send.push_back(pair_of(0, 0, 8000, 0, 4000, 0, 2000, 0));
      pairs_to_send.push_back(pair_of(0, 0, -2000, 0, 4000, 0, -8000, 0));
      pairs_to_send.push_back(pair_of(0, 0, 3000, 500, 3000, 2000, -700, 900));
      pairs_to_send.push_back(pair_of(0, 0, 4096, 4096, 3000, 3000, 4096, 4096));
      pairs_to_send.push_back(pair_of(0, 0, 8388607, 8388607, 3000, 1000,
                                      -8388608, -8388608));
      pairs_to_send.push_back(pair_of(10, -7, 8388607, -8388608, 1500, 2900,
                                      -8388608, 8388607));
      pairs_to_send.push_back(pair_of(-8388608, -8388608, 1, 1, 8388607, 8388607, -1, -1));
      pairs_to_send.push_back(pair_of(8388607, 8388607, -8388608, -8388608,
                                      8388606, 8388607, 8388607, 8388607));
      pairs_to_send.push_back(pair_of(-8388608, 5, 8388607, 0, -8388607, 5, -8388608, 0));
      pairs_to_send.push_back(pair_of(0, 0, 0, 0, 1, 0, 0, 0));
      pairs_to_send.push_back(pair_of(0, 0, 0, 0, 0, 1, 0, -1));
      pairs_to_send.push_back(pair_of(-1, -1, -1, -1, 0, 0, -1, -1));
      set_radius(23'd0);
      pairs_to_send.push_back(pair_of(0, 0, 4096, 0, 1, 0, -4096, 0));
      pairs_to_send.push_back(pair_of(0, 0, 4096, 0, 0, 0, -4096, 0));
      random_phase(23'd8388607, 18, 180);
      random_phase(23'd4096, 18, 190);
      random_phase(23'd1, 66, 150);
      random_phase(23'($urandom_range(2, 60000)), 66, 190);
      random_phase(23'd300, 0, 190);
      random_phase(23'($urandom_range(60000, 8388606)), 0, 200);
      settle();
      if (errors == 0) begin
         $display("disk_pair_elastic_collision_core_tb: PASS");
      end else begin
         $display("disk_pair_elastic_collision_core_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("disk_pair_elastic_collision_core_tb: FAIL");
      $finish;
   end
endmodule
